### design/bcdtod_pkg.sv
// Package for the BCD time-of-day updater.
// Holds the field widths and the time constants shared by the core,
// its digit converter and its checker. Depends on nothing.
package bcdtod_pkg;

  localparam int unsigned ReadingW = 24;
  localparam int unsigned TodW     = 24;
  localparam int unsigned SumW     = 26;

  localparam int unsigned SecCs    = 100;
  localparam int unsigned MinCs    = 6000;
  localparam int unsigned HourCs   = 360000;
  localparam int unsigned DayCs    = 8640000;
  localparam int unsigned BcdRadix = 10;

  // Residue of the 32-bit wrap modulo one day.
  localparam longint unsigned WrapRem = (64'd1 << 32) % 64'(DayCs);

  // Register stages from an input transfer to the output register.
  localparam int unsigned PipeDepth = 5;

endpackage

### design/bcdtod_digits.sv
// Pipelined conversion of a centiseconds-of-day value to four BCD pairs.
// Depends on bcdtod_pkg for the time constants.
module bcdtod_digits (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bcdtod_pkg::TodW-1:0]  tod,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [5:0]                   hours_bcd,
  output logic [6:0]                   minutes_bcd,
  output logic [6:0]                   seconds_bcd,
  output logic [7:0]                   hundredths_bcd
);
  import bcdtod_pkg::*;

  typedef struct packed {
    logic [4:0]  hours;
    logic [18:0] rem;
  } hr_split_t;

  typedef struct packed {
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [12:0] rem;
  } min_split_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [6:0] hundredths;
  } hms_t;

  function automatic logic [7:0] bin2bcd(input logic [6:0] v);
    logic [3:0] tens;
    logic [3:0] units;
    tens  = '0;
    units = v[3:0];
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(k * BcdRadix)) begin
        tens  = 4'(k);
        units = 4'(v - 7'(k * BcdRadix));
      end
    end
    return {tens, units};
  endfunction

  logic       v1, v2, v3;
  logic       rdy1, rdy2, rdy3, rdy4;
  hr_split_t  s1, s1_next;
  min_split_t s2, s2_next;
  hms_t       s3, s3_next;
  logic [7:0] hr_bcd, mn_bcd, sc_bcd, cs_bcd;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    s1_next.hours = '0;
    s1_next.rem   = tod[18:0];
    for (int k = 1; k < 24; k++) begin
      if (tod >= TodW'(k * HourCs)) begin
        s1_next.hours = 5'(k);
        s1_next.rem   = 19'(tod - TodW'(k * HourCs));
      end
    end
  end

  always_comb begin
    s2_next.hours   = s1.hours;
    s2_next.minutes = '0;
    s2_next.rem     = s1.rem[12:0];
    for (int k = 1; k < 60; k++) begin
      if (s1.rem >= 19'(k * MinCs)) begin
        s2_next.minutes = 6'(k);
        s2_next.rem     = 13'(s1.rem - 19'(k * MinCs));
      end
    end
  end

  always_comb begin
    s3_next.hours      = s2.hours;
    s3_next.minutes    = s2.minutes;
    s3_next.seconds    = '0;
    s3_next.hundredths = s2.rem[6:0];
    for (int k = 1; k < 60; k++) begin
      if (s2.rem >= 13'(k * SecCs)) begin
        s3_next.seconds    = 6'(k);
        s3_next.hundredths = 7'(s2.rem - 13'(k * SecCs));
      end
    end
  end

  assign hr_bcd = bin2bcd({2'b00, s3.hours});
  assign mn_bcd = bin2bcd({1'b0, s3.minutes});
  assign sc_bcd = bin2bcd({1'b0, s3.seconds});
  assign cs_bcd = bin2bcd(s3.hundredths);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1 <= s1_next;
    if (rdy2 && v1) s2 <= s2_next;
    if (rdy3 && v2) s3 <= s3_next;
    if (rdy4 && v3) begin
      hours_bcd      <= hr_bcd[5:0];
      minutes_bcd    <= mn_bcd[6:0];
      seconds_bcd    <= sc_bcd[6:0];
      hundredths_bcd <= cs_bcd;
    end
  end

endmodule

### design/bcd_time_of_day_updater_core.sv
// Each accepted reading advances the time of day by its wrapping difference
// from the previous reading and yields one result, the time as four BCD pairs.
// The block takes one reading per cycle while the output is not stalled; each
// result goes through the time-of-day register and the conversion stages. The
// rate is set by the time-of-day register, updated by a modular add; the
// conversion to BCD runs in four further stages, each able to move on while
// a later stage holds a waiting result.
// Top level; depends on bcdtod_pkg and bcdtod_digits.
module bcd_time_of_day_updater_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bcdtod_pkg::ReadingW-1:0] reading,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [5:0]                      hours_bcd,
  output logic [6:0]                      minutes_bcd,
  output logic [6:0]                      seconds_bcd,
  output logic [7:0]                      hundredths_bcd
);
  import bcdtod_pkg::*;

  logic [ReadingW-1:0] prev;
  logic [TodW-1:0]     tod, tod_next;
  logic [SumW-1:0]     sum;
  logic                v0;
  logic                dig_ready;
  logic                take;

  assign in_ready = !v0 || dig_ready;
  assign take     = in_valid && in_ready;

  // A backwards step adds the residue of the 32-bit wrap; the offset of two
  // days keeps the sum non-negative before it is folded into one day.
  always_comb begin
    sum = SumW'(tod) + SumW'(reading) - SumW'(prev) + SumW'(2 * DayCs)
        + ((reading < prev) ? SumW'(WrapRem) : SumW'(0));
    tod_next = sum[TodW-1:0];
    for (int k = 1; k < 5; k++) begin
      if (sum >= SumW'(k * DayCs)) begin
        tod_next = TodW'(sum - SumW'(k * DayCs));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      prev <= '0;
      tod  <= '0;
    end else begin
      if (in_ready) v0 <= in_valid;
      if (take) begin
        prev <= reading;
        tod  <= tod_next;
      end
    end
  end

  bcdtod_digits u_digits (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (v0),
    .in_ready       (dig_ready),
    .tod            (tod),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hours_bcd      (hours_bcd),
    .minutes_bcd    (minutes_bcd),
    .seconds_bcd    (seconds_bcd),
    .hundredths_bcd (hundredths_bcd)
  );

endmodule

### design/bcdtod_checker.sv
// Port-level checker for the BCD time-of-day updater, bound to the top level.
// Depends on bcdtod_pkg for the pipeline depth.
module bcdtod_port_checks (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [bcdtod_pkg::ReadingW-1:0] reading,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [5:0]                      hours_bcd,
  input logic [6:0]                      minutes_bcd,
  input logic [6:0]                      seconds_bcd,
  input logic [7:0]                      hundredths_bcd
);
  import bcdtod_pkg::*;

  logic [2:0] pending;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending <= pending + 3'd1;
    end else if (!in_xfer && out_xfer) begin
      pending <= pending - 3'd1;
    end
  end

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("Result shown without an outstanding input transfer.");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'(PipeDepth))
    else $error("More items in flight than the pipeline holds.");

  a_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hours_bcd <= 6'h23 && minutes_bcd <= 7'h59
      && seconds_bcd <= 7'h59 && hundredths_bcd <= 8'h99
      && hours_bcd[3:0] <= 4'd9 && minutes_bcd[3:0] <= 4'd9
      && seconds_bcd[3:0] <= 4'd9 && hundredths_bcd[3:0] <= 4'd9)
    else $error("Result holds a time that is not valid BCD.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hours_bcd)
      && $stable(minutes_bcd) && $stable(seconds_bcd) && $stable(hundredths_bcd))
    else $error("Stalled result changed before its transfer.");

endmodule

bind bcd_time_of_day_updater_core bcdtod_port_checks u_bcdtod_port_checks (.*);

### bench/bcdtod_checker.sv
// Checker for the BCD time-of-day updater: watches both channels, predicts each
// result from the accepted readings and compares it field by field.
// Depends on bcdtod_pkg for the reading width and the time constants.
module bcdtod_checker
  import bcdtod_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [ReadingW-1:0] reading,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [5:0]          hours_bcd,
  input  logic [6:0]          minutes_bcd,
  input  logic [6:0]          seconds_bcd,
  input  logic [7:0]          hundredths_bcd,
  output int                  fail_count,
  output int                  pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CsPerSec    = SecCs;
  localparam int unsigned SecPerMin   = MinCs / SecCs;
  localparam int unsigned MinPerHour  = HourCs / MinCs;
  localparam int unsigned HoursPerDay = DayCs / HourCs;
  localparam int          ReportLimit = 10;

  typedef struct packed {
    logic [5:0] hours;
    logic [6:0] minutes;
    logic [6:0] seconds;
    logic [7:0] hundredths;
  } tod_bcd_t;

  logic [ReadingW-1:0] last_reading;
  int unsigned         cs_count;
  int unsigned         sec_count;
  int unsigned         min_count;
  int unsigned         hour_count;
  tod_bcd_t            expected_times[$];
  int                  mismatches = 0;

  function automatic int unsigned add_wrapped(input int unsigned value,
                                              input int unsigned delta,
                                              input int unsigned modulus,
                                              output int unsigned sum);
    int unsigned carry;
    int unsigned v;
    carry = delta / modulus;
    v = value + delta % modulus;
    if (v >= modulus) begin
      carry += v / modulus;
      v = v % modulus;
    end
    sum = v;
    return carry;
  endfunction

  function automatic logic [7:0] to_bcd(input int unsigned v);
    return {4'(v / BcdRadix), 4'(v % BcdRadix)};
  endfunction

  function automatic tod_bcd_t advance_clock(input logic [ReadingW-1:0] now);
    int unsigned delta;
    tod_bcd_t    t;
    delta = 32'(now) - 32'(last_reading);
    last_reading = now;
    delta = add_wrapped(cs_count, delta, CsPerSec, cs_count);
    delta = add_wrapped(sec_count, delta, SecPerMin, sec_count);
    delta = add_wrapped(min_count, delta, MinPerHour, min_count);
    void'(add_wrapped(hour_count, delta, HoursPerDay, hour_count));
    t.hours      = 6'(to_bcd(hour_count));
    t.minutes    = 7'(to_bcd(min_count));
    t.seconds    = 7'(to_bcd(sec_count));
    t.hundredths = to_bcd(cs_count);
    return t;
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= ReportLimit) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) note_failure($sformatf("%s expected %0h, got %0h", name, want, got));
  endfunction

  always @(posedge clk) begin
    tod_bcd_t want;
    if (rst) begin
      last_reading = '0;
      cs_count     = 0;
      sec_count    = 0;
      min_count    = 0;
      hour_count   = 0;
      expected_times.delete();
    end else begin
      if (in_valid && in_ready) expected_times.push_back(advance_clock(reading));
      if (out_valid && out_ready) begin
        if (expected_times.size() == 0) begin
          note_failure($sformatf("unexpected result %0h:%0h:%0h.%0h", hours_bcd,
                                 minutes_bcd, seconds_bcd, hundredths_bcd));
        end else begin
          want = expected_times.pop_front();
          check_field("hours", want.hours, hours_bcd);
          check_field("minutes", want.minutes, minutes_bcd);
          check_field("seconds", want.seconds, seconds_bcd);
          check_field("hundredths", want.hundredths, hundredths_bcd);
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_times.size();
  end

endmodule

### bench/tb_bcd_time_of_day_updater_core.sv
// Testbench top for the BCD time-of-day updater: drives readings and output stalls
// and gives the verdict from the failure count of bcdtod_checker.
// Depends on bcdtod_pkg, bcdtod_checker and the bcd_time_of_day_updater_core RTL.
module tb_bcd_time_of_day_updater_core;

  timeunit 1ns;
  timeprecision 1ps;

  import bcdtod_pkg::*;

  localparam int                  HoldCycles = 300;
  localparam logic [ReadingW-1:0] MaxReading = ReadingW'(DayCs - 1);
  localparam int                  PhaseItems = 200;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [ReadingW-1:0] reading   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [5:0]          hours_bcd;
  logic [6:0]          minutes_bcd;
  logic [6:0]          seconds_bcd;
  logic [7:0]          hundredths_bcd;

  int                  fail_count;
  int                  pending;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  logic                hold_req      = 1'b0;
  int                  hold_count    = 0;
  int                  readings_sent = 0;
  logic [ReadingW-1:0] last_sent     = '0;

  bcd_time_of_day_updater_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .reading        (reading),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hours_bcd      (hours_bcd),
    .minutes_bcd    (minutes_bcd),
    .seconds_bcd    (seconds_bcd),
    .hundredths_bcd (hundredths_bcd)
  );

  bcdtod_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .reading        (reading),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hours_bcd      (hours_bcd),
    .minutes_bcd    (minutes_bcd),
    .seconds_bcd    (seconds_bcd),
    .hundredths_bcd (hundredths_bcd),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req && hold_count < HoldCycles) begin
      out_ready  <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_reading(input logic [ReadingW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    reading  <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    last_sent = value;
    readings_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [ReadingW-1:0] next_reading();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return last_sent + ReadingW'($urandom_range(1000));
    if (pick < 65) return last_sent + ReadingW'($urandom_range(HourCs * 3));
    if (pick < 75) return last_sent;
    if (pick < 85) return last_sent - ReadingW'($urandom_range(2000));
    if (pick < 95) return ReadingW'($urandom_range(MaxReading));
    return ReadingW'($urandom);
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_reading(next_reading());
  endtask

  initial begin
    #500000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_reading(0);
    send_reading(0);
    send_reading(1);
    send_reading(99);
    send_reading(100);
    send_reading(5999);
    send_reading(6000);
    send_reading(359999);
    send_reading(360000);
    send_reading(MaxReading);
    send_reading(MaxReading);
    send_reading(0);
    send_reading(MaxReading);
    send_reading(10);
    send_reading(5);
    send_reading(24'hFFFFFF);
    send_reading(24'h800000);
    send_reading(ReadingW'(DayCs));
    send_reading(24'hAAAAAA);
    send_reading(24'h555555);
    send_reading(1);
    send_reading(0);
    wait_for_results();

    send_idle_pct = 6;
    recv_idle_pct <= 84;
    run_random(PhaseItems);

    send_idle_pct = 84;
    recv_idle_pct <= 6;
    run_random(PhaseItems);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req <= 1'b1;
    run_random(40);
    wait_for_results();
    hold_req <= 1'b0;

    run_random(140);
    wait_for_results();
    repeat (PipeDepth * 4) @(posedge clk);

    $display("Sent %0d readings: day boundaries, repeats, backward and out-of-range steps,",
             readings_sent);
    $display("random steps under sender and receiver stalls and one long output hold-off.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
